// File: rtl/rscsf_pkg.sv
// ----------------------------------------------------------------------------
// rscsf_pkg
// Shared types and constants for the rank set count/sum Fenwick unit:
// field widths, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rscsf_pkg;

  // Field widths of the input and result words
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 10;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 11;
  localparam int SUM_W     = 64;

  // Default number of rank slots
  localparam int DEPTH_DEF = 1024;

  // Command codes; code 3 is unused and behaves as a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_code_t;

  // Controller state
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;  // write zero to both memories at the clear pointer
    logic accept;    // capture the input word and start the entry lookup
    logic look;      // entry data is back: update entry, latch deltas
    logic walk;      // one tree node per cycle
    logic out_load;  // load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;   // clear pointer is at the last entry
    logic active;     // command changes the trees or walks them
    logic walk_more;  // next tree node is in range
    logic out_free;   // result register can take a word this cycle
  } ctrl_sts_t;

endpackage

// File: rtl/rscsf_ram.sv
// ----------------------------------------------------------------------------
// rscsf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rscsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/rscsf_ctrl.sv
// ----------------------------------------------------------------------------
// rscsf_ctrl
// Sequencer for the Fenwick unit: clearing pass after reset, entry lookup,
// tree walk one node per cycle, and result hand-off.
// ----------------------------------------------------------------------------
module rscsf_ctrl
  import rscsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = sts.active ? ST_WALK : ST_OUT;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.walk_more) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/rscsf_datapath.sv
// ----------------------------------------------------------------------------
// rscsf_datapath
// Entry memory (present bit and stored value), combined count/sum tree
// memory, walk index, accumulators, member count and result register.
// ----------------------------------------------------------------------------
module rscsf_datapath
  import rscsf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CNT_OUT_W-1:0]    out_count_upto,
  output logic signed [SUM_W-1:0] out_sum_upto,
  output logic [CNT_OUT_W-1:0]    out_member_total
);

  localparam int AW  = $clog2(DEPTH);
  localparam int IW  = $clog2(DEPTH + 1) + 1;
  localparam int CW  = ($clog2(DEPTH + 1) > CNT_OUT_W) ? $clog2(DEPTH + 1) : CNT_OUT_W;
  localparam int EW  = VAL_W + 1;
  localparam int TW  = CW + SUM_W;

  // Captured command word
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [VAL_W-1:0]  val_r;
  logic              in_range_r;

  // Walk state
  logic [IW-1:0]    idx_r;
  logic [CW-1:0]    dcnt_r;
  logic [SUM_W-1:0] dsum_r;
  logic [CW-1:0]    acc_cnt_r;
  logic [SUM_W-1:0] acc_sum_r;
  logic [CW-1:0]    member_cnt_r;
  logic [AW-1:0]    clr_r;

  // Result register
  logic                 out_valid_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic [CNT_OUT_W-1:0] out_total_r;

  // Memory ports
  logic          ent_wr_en;
  logic [AW-1:0] ent_wr_addr;
  logic [EW-1:0] ent_wr_data;
  logic [AW-1:0] ent_rd_addr;
  logic [EW-1:0] ent_rd_data;
  logic          tree_wr_en;
  logic [AW-1:0] tree_wr_addr;
  logic [TW-1:0] tree_wr_data;
  logic [AW-1:0] tree_rd_addr;
  logic [TW-1:0] tree_rd_data;

  // Decoded values
  logic             is_upd;
  logic             present;
  logic [VAL_W-1:0] stored_val;
  logic             active;
  logic [IW-1:0]    low_bit;
  logic [IW-1:0]    idx_nxt;
  logic [31:0]      slot_w;
  logic [31:0]      slot_sat;
  logic [CW-1:0]    node_cnt;
  logic [SUM_W-1:0] node_sum;

  rscsf_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data)
  );

  rscsf_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tree_ram (
    .clk     (clk),
    .wr_en   (tree_wr_en),
    .wr_addr (tree_wr_addr),
    .wr_data (tree_wr_data),
    .rd_addr (tree_rd_addr),
    .rd_data (tree_rd_data)
  );

  // Decode the captured command and the entry lookup
  assign is_upd     = (cmd_r == CMD_INSERT) || (cmd_r == CMD_REMOVE);
  assign present    = ent_rd_data[VAL_W];
  assign stored_val = ent_rd_data[VAL_W-1:0];
  assign node_cnt   = tree_rd_data[TW-1:SUM_W];
  assign node_sum   = tree_rd_data[SUM_W-1:0];

  always_comb begin
    case (cmd_r)
      CMD_INSERT: active = in_range_r && !present;
      CMD_REMOVE: active = in_range_r && present;
      CMD_QUERY:  active = 1'b1;
      default:    active = 1'b0;
    endcase
  end

  // Next tree node: climb for updates, descend for queries
  assign low_bit = idx_r & (~idx_r + IW'(1));
  assign idx_nxt = is_upd ? (idx_r + low_bit) : (idx_r - low_bit);

  // Saturate the query slot to the last rank
  assign slot_w   = 32'(in_slot);
  assign slot_sat = (slot_w >= 32'(DEPTH)) ? 32'(DEPTH - 1) : slot_w;

  // Entry memory: clear, or set/clear the present bit on a live update
  assign ent_rd_addr = AW'(in_slot);
  assign ent_wr_en   = cmd.clr_step || (cmd.look && active && is_upd);
  assign ent_wr_addr = cmd.clr_step ? clr_r : AW'(slot_r);
  assign ent_wr_data = cmd.clr_step ? '0 :
                       ((cmd_r == CMD_INSERT) ? {1'b1, val_r} : {1'b0, stored_val});

  // Tree memory: read node idx, write it back with the delta next cycle
  assign tree_rd_addr = cmd.look ? AW'(idx_r - IW'(1)) : AW'(idx_nxt - IW'(1));
  assign tree_wr_en   = cmd.clr_step || (cmd.walk && is_upd);
  assign tree_wr_addr = cmd.clr_step ? clr_r : AW'(idx_r - IW'(1));
  assign tree_wr_data = cmd.clr_step ? '0 : {node_cnt + dcnt_r, node_sum + dsum_r};

  // Status back to the controller
  assign sts.clr_last  = (clr_r == AW'(DEPTH - 1));
  assign sts.active    = active;
  assign sts.walk_more = is_upd ? (32'(idx_nxt) <= 32'(DEPTH)) : (idx_nxt != '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // Capture the input word and seed the walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r      <= in_cmd;
      slot_r     <= in_slot;
      val_r      <= in_entry_value;
      in_range_r <= (slot_w < 32'(DEPTH));
      idx_r      <= IW'(slot_sat + 32'd1);
    end else if (cmd.walk) begin
      idx_r <= idx_nxt;
    end
  end

  // Latch the tree deltas once the entry is known
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      if (cmd_r == CMD_INSERT) begin
        dcnt_r <= CW'(1);
        dsum_r <= {{(SUM_W-VAL_W){val_r[VAL_W-1]}}, val_r};
      end else begin
        dcnt_r <= '1;
        dsum_r <= -{{(SUM_W-VAL_W){stored_val[VAL_W-1]}}, stored_val};
      end
    end
  end

  // Prefix accumulators, zero unless a query walks
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_cnt_r <= '0;
      acc_sum_r <= '0;
    end else if (cmd.walk && !is_upd) begin
      acc_cnt_r <= acc_cnt_r + node_cnt;
      acc_sum_r <= acc_sum_r + node_sum;
    end
  end

  // Member count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_cnt_r <= '0;
    end else if (cmd.look && active && is_upd) begin
      member_cnt_r <= (cmd_r == CMD_INSERT) ? (member_cnt_r + CW'(1))
                                            : (member_cnt_r - CW'(1));
    end
  end

  // Result register: hold until the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cnt_r   <= acc_cnt_r[CNT_OUT_W-1:0];
      out_sum_r   <= acc_sum_r;
      out_total_r <= member_cnt_r[CNT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count_upto   = out_cnt_r;
  assign out_sum_upto     = out_sum_r;
  assign out_member_total = out_total_r;

endmodule

// File: rtl/rank_set_count_sum_fenwick_unit.sv
// ----------------------------------------------------------------------------
// rank_set_count_sum_fenwick_unit
// Set of rank-indexed members with signed values, backed by Fenwick trees
// of member counts and value sums; insert, remove and prefix query.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over every entry of its entry
// and tree memories and holds in_stall high until it finishes. Each word
// then passes entry lookup, the tree walk and result hand-off before the
// next word is accepted. The walk visits N tree nodes, where N is up to
// floor(log2(DEPTH)) + 1 for an insert or remove that changes the set, the
// number of set bits in slot+1 for a query, and zero for a command that
// changes nothing. The tree memory is read and written back at one node
// per cycle. One result word leaves per command; it waits in an output
// register, so the next command may be taken while it is still stalled.
module rank_set_count_sum_fenwick_unit
  import rscsf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic signed [VAL_W-1:0] in_entry_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CNT_OUT_W-1:0]    out_count_upto,
  output logic signed [SUM_W-1:0] out_sum_upto,
  output logic [CNT_OUT_W-1:0]    out_member_total
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rscsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rscsf_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_entry_value   (in_entry_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_count_upto   (out_count_upto),
    .out_sum_upto     (out_sum_upto),
    .out_member_total (out_member_total)
  );

`ifndef SYNTHESIS
  // One word at a time: an accepted word blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // Accept never overlaps clearing, lookup, walking or result loading
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!cmd.clr_step && !cmd.look && !cmd.walk && !cmd.out_load))
    else $error("accept overlaps another datapath command");

  // Prefix count never exceeds the member total on a valid result, checked when DEPTH is at most 2047
  a_count_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((DEPTH > 2047) || (out_count_upto <= out_member_total)))
    else $error("prefix count above member total");
`endif

endmodule
